// ===== sv/split_virtqueue_descriptor_manager_macros.svh =====
// Assertion macros for the split virtqueue descriptor manager.
// No dependencies.
`ifndef SPLIT_VIRTQUEUE_DESCRIPTOR_MANAGER_MACROS_SVH
`define SPLIT_VIRTQUEUE_DESCRIPTOR_MANAGER_MACROS_SVH
// Property that must hold at every edge outside reset.
`define SVQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SVQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== sv/svq_pkg.sv =====
// Package for the split virtqueue descriptor manager: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svq_pkg;
   // Number of descriptors; a power of two from 2 to 32.
   localparam int NUM_DESC_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_PUSH = 2'd1,
      OP_DEQ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_DROPPED = 2'd1,
      ST_EMPTY = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [63:0] buf_addr;
      logic [31:0] buf_len;
      logic [15:0] token_flags;
      logic [5:0] chain_length;
      logic [4:0] used_id;
      logic [31:0] used_len;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] desc_index;
      logic [4:0] avail_slot;
      logic chain_published;
      logic [63:0] out_addr;
      logic [31:0] out_len;
      logic [15:0] out_flags;
      logic [31:0] written_len;
      logic last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the request
      logic exec;       // execute enqueue or push and form its result, or form an empty dequeue's result
      logic deq_start;  // read used ring, begin the walk
      logic deq_read;   // read table at the current descriptor
      logic deq_emit;   // form one walk result and return the descriptor
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic deq_empty;
      logic deq_more;
   } sts_type;
endpackage
`default_nettype wire

// ===== sv/svq_if.sv =====
// Valid/ready channel interface carrying one payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface svq_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/svq_ctrl.sv =====
// Controller state machine for the descriptor manager.
// Depends on svq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svq_ctrl import svq_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EXEC = 6'b000010,
      S_DSTART = 6'b000100,
      S_DREAD = 6'b001000,
      S_DEMIT = 6'b010000,
      S_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic more_ff, more_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      more_in = more_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.opcode == OP_DEQ) begin
               cmd.deq_start = 1'b1;
               state_in = S_DSTART;
            end else if (sts.opcode == OP_NONE) begin
               state_in = S_IDLE;
            end else begin
               cmd.exec = 1'b1;
               more_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_DSTART: begin
            if (sts.deq_empty) begin
               cmd.exec = 1'b1;
               more_in = 1'b0;
               state_in = S_OUT;
            end else begin
               cmd.deq_read = 1'b1;
               state_in = S_DREAD;
            end
         end
         S_DREAD: begin
            cmd.deq_emit = 1'b1;
            more_in = sts.deq_more;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (more_ff) begin
                  cmd.deq_read = 1'b1;
                  state_in = S_DREAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         more_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         more_ff <= more_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/svq_dp.sv =====
// Datapath: descriptor tables, free stack, used ring, avail and used indices.
// Depends on svq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svq_dp import svq_pkg::*; #(
   parameter int NUM_DESC = NUM_DESC_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input req_type req_data,
   input cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);
   localparam int IW = $clog2(NUM_DESC);
   localparam int CW = $clog2(NUM_DESC + 1);
   localparam int MAX_WALK = (NUM_DESC < 32) ? NUM_DESC : 32;

   // Descriptor tables with per-entry valid bits standing for the zero reset.
   logic [63:0] addr_mem [NUM_DESC];
   logic [31:0] len_mem [NUM_DESC];
   logic [15:0] flags_mem [NUM_DESC];
   logic [IW-1:0] next_mem [NUM_DESC];
   logic [NUM_DESC-1:0] dvalid_ff;
   logic [NUM_DESC-1:0] nvalid_ff;
   logic [IW-1:0] stack_ff [NUM_DESC];
   logic [IW-1:0] used_id_mem [NUM_DESC];
   logic [31:0] used_len_mem [NUM_DESC];

   logic [CW-1:0] free_count_ff;
   logic [15:0] avail_idx_ff, used_idx_ff, last_used_ff;
   logic [5:0] tokens_left_ff;
   logic [IW-1:0] prev_ff;
   logic dropping_ff;
   req_type req_ff;
   rsp_type rsp_ff;
   logic [IW-1:0] cur_ff;
   logic [31:0] wlen_ff;
   logic [5:0] walk_ff;
   logic [63:0] rd_addr_ff;
   logic [31:0] rd_len_ff;
   logic [15:0] rd_flags_ff;
   logic [IW-1:0] rd_next_ff;
   logic rd_dv_ff, rd_nv_ff;

   // Enqueue, push and walk decisions.
   logic first;
   logic [5:0] n_eff, tl_after;
   logic drop_now;
   logic [IW-1:0] pop_d;
   logic [15:0] pending;
   logic [15:0] fl_eff;
   logic more_w;
   logic link_prev;
   logic [NUM_DESC-1:0] nv_set;
   rsp_type exec_rsp;

   always_comb begin
      first = (tokens_left_ff == 6'd0);
      n_eff = (req_ff.chain_length == 6'd0) ? 6'd1 : req_ff.chain_length;
      if (first) begin
         drop_now = ({1'b0, n_eff} > 7'(free_count_ff)) || (free_count_ff == '0);
         tl_after = n_eff - 6'd1;
      end else begin
         drop_now = dropping_ff || (free_count_ff == '0);
         tl_after = tokens_left_ff - 6'd1;
      end
      pop_d = stack_ff[IW'(free_count_ff - CW'(1))];
      pending = used_idx_ff - last_used_ff;
      fl_eff = rd_dv_ff ? rd_flags_ff : 16'd0;
      more_w = fl_eff[0] && ((walk_ff + 6'd1) < 6'(MAX_WALK));
      // When the popped descriptor is the previous one and ends the chain, the
      // clear of its next entry takes precedence over the link.
      link_prev = !first && !(!req_ff.token_flags[0] && (prev_ff == pop_d));
      nv_set = '0;
      if (!first) nv_set[prev_ff] = 1'b1;
      if (!req_ff.token_flags[0]) nv_set[pop_d] = 1'b1;
      exec_rsp = '0;
      exec_rsp.last = 1'b1;
      case (req_ff.opcode)
         OP_ENQ: begin
            if (drop_now) begin
               exec_rsp.status = ST_DROPPED;
            end else begin
               exec_rsp.desc_index = 5'(pop_d);
               if (tl_after == 6'd0) begin
                  exec_rsp.avail_slot = 5'(avail_idx_ff[IW-1:0]);
                  exec_rsp.chain_published = 1'b1;
               end
            end
         end
         OP_PUSH: begin
            if (pending >= 16'(NUM_DESC)) exec_rsp.status = ST_OVERFLOW;
         end
         default: exec_rsp.status = ST_EMPTY;
      endcase
   end

   assign sts.opcode = req_ff.opcode;
   assign sts.deq_empty = (last_used_ff == used_idx_ff);
   assign sts.deq_more = more_w;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec && req_ff.opcode == OP_ENQ && !drop_now) begin
         addr_mem[pop_d] <= req_ff.buf_addr;
         len_mem[pop_d] <= req_ff.buf_len;
         flags_mem[pop_d] <= req_ff.token_flags;
      end
      if (cmd.exec && req_ff.opcode == OP_PUSH && pending < 16'(NUM_DESC)) begin
         // The depth is a power of two, so the size cast reduces the id.
         used_id_mem[used_idx_ff[IW-1:0]] <= IW'(req_ff.used_id);
         used_len_mem[used_idx_ff[IW-1:0]] <= req_ff.used_len;
      end
      if (cmd.deq_read) begin
         rd_addr_ff <= addr_mem[cur_ff];
         rd_len_ff <= len_mem[cur_ff];
         rd_flags_ff <= flags_mem[cur_ff];
         rd_next_ff <= next_mem[cur_ff];
         rd_dv_ff <= dvalid_ff[cur_ff];
         rd_nv_ff <= nvalid_ff[cur_ff];
      end
      if (cmd.deq_start) begin
         cur_ff <= used_id_mem[last_used_ff[IW-1:0]];
         wlen_ff <= used_len_mem[last_used_ff[IW-1:0]];
         walk_ff <= 6'd0;
      end
      if (cmd.deq_emit) begin
         rsp_ff <= '{status: ST_OK, desc_index: 5'(cur_ff), avail_slot: 5'd0,
                     chain_published: 1'b0,
                     out_addr: rd_dv_ff ? rd_addr_ff : 64'd0,
                     out_len: rd_dv_ff ? rd_len_ff : 32'd0,
                     out_flags: fl_eff, written_len: wlen_ff, last: !more_w};
         cur_ff <= rd_nv_ff ? rd_next_ff : '0;
         walk_ff <= walk_ff + 6'd1;
      end
      if (cmd.exec) rsp_ff <= exec_rsp;
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
         nvalid_ff <= '0;
         for (int i = 0; i < NUM_DESC; i++) stack_ff[i] <= IW'(i);
         free_count_ff <= CW'(NUM_DESC);
         avail_idx_ff <= '0;
         used_idx_ff <= '0;
         last_used_ff <= '0;
         tokens_left_ff <= '0;
         prev_ff <= '0;
         dropping_ff <= 1'b0;
      end else begin
         if (cmd.exec && req_ff.opcode == OP_ENQ) begin
            tokens_left_ff <= tl_after;
            if (drop_now) begin
               dropping_ff <= (tl_after != 6'd0);
            end else begin
               dropping_ff <= 1'b0;
               free_count_ff <= free_count_ff - CW'(1);
               dvalid_ff[pop_d] <= 1'b1;
               nvalid_ff <= nvalid_ff | nv_set;
               if (link_prev) next_mem[prev_ff] <= pop_d;
               if (!req_ff.token_flags[0]) next_mem[pop_d] <= '0;
               prev_ff <= pop_d;
               if (tl_after == 6'd0) avail_idx_ff <= avail_idx_ff + 16'd1;
            end
         end
         if (cmd.exec && req_ff.opcode == OP_PUSH && pending < 16'(NUM_DESC))
            used_idx_ff <= used_idx_ff + 16'd1;
         if (cmd.deq_emit) begin
            if (free_count_ff < CW'(NUM_DESC)) begin
               stack_ff[IW'(free_count_ff)] <= cur_ff;
               free_count_ff <= free_count_ff + CW'(1);
            end
            if (!more_w) last_used_ff <= last_used_ff + 16'd1;
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/split_virtqueue_descriptor_manager.sv =====
// Split virtqueue descriptor manager, driver side.
// Enqueue and push: the request is registered, then executed, then its result is
// offered; no new transaction is taken until the result has been taken.
// Dequeue: the used ring is read, then each descriptor of the chain is read from the
// registered descriptor table read and offered in turn; an empty used ring gives one result.
// Reset is synchronous and active high; tables read as zero until written.
`timescale 1ns / 1ps
`default_nettype none
`include "split_virtqueue_descriptor_manager_macros.svh"
module split_virtqueue_descriptor_manager import svq_pkg::*; #(
   parameter int NUM_DESC = NUM_DESC_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   svq_if.sink req,
   svq_if.source rsp
);
   // The controller sequences each transaction; the datapath holds the tables, rings and indices.
   cmd_type cmd;
   sts_type sts;
   logic req_ready, rsp_valid;

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

   svq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   svq_dp #(.NUM_DESC(NUM_DESC)) u_dp (
      .clock(clock), .reset(reset),
      .req_data(req.data), .cmd(cmd), .sts(sts), .rsp_data(rsp.data)
   );

   // The block never takes a new transaction while a result is on offer.
   `SVQ_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "ready while result pending")
   // At most one datapath command at a time.
   `SVQ_ASSERT(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")
   // An accepted transaction never produces a result in the very next cycle.
   `SVQ_ASSERT_NEXT(a_latency, req.valid && req_ready, !rsp_valid, "result too early")
endmodule
`default_nettype wire
